[hdl/nesting_range_closer_assert.svh]
// assertion macros for the nesting range closer checker
// no dependencies; clock and reset are passed in by the user of each macro
`ifndef NESTING_RANGE_CLOSER_ASSERT_SVH
`define NESTING_RANGE_CLOSER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define NRC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nrc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define NRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nrc assertion failed");

`endif

[hdl/nrc_pkg.sv]
// shared types and constants for the nesting range closer
// no dependencies
package nrc_pkg;

    localparam int DEPTH_BITS = 8;
    localparam int OP_BITS    = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_ENTRY = 2'd0,
        OP_SLOT  = 2'd1,
        OP_END   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic accept;     // input word taken this cycle
        logic read;       // fetch top of stack
        logic pop;        // move fetched top into the pending slot
        logic emit;       // load pending range into the output register
        logic emit_last;  // emitted word is the last one for this item
        logic clear_pend; // pending slot handed over
        logic finish;     // push new entry or reset index at end of document
    } cmd_t;

    typedef struct packed {
        logic closes;     // input word is an entry or end of document
        logic pop_ok;     // fetched top must be closed
        logic pend_valid; // a closed range is waiting for its last flag
        logic out_free;   // output register can take a word
    } status_t;

endpackage

[hdl/nrc_datapath.sv]
// datapath: open-entry stack memory, item registers, pending range and output register
// depends on nrc_pkg
module nrc_datapath #(
    parameter int STACK_DEPTH = 32,
    parameter int LINE_BITS   = 24,
    parameter int INDEX_BITS  = 16,
    parameter int S_TDATA_W   = 56,
    parameter int M_TDATA_W   = 72
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [S_TDATA_W-1:0]          s_tdata,
    input  logic [nrc_pkg::OP_BITS-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [M_TDATA_W-1:0]          m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  nrc_pkg::cmd_t                 cmd,
    output nrc_pkg::status_t              status
);

    localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int DB    = nrc_pkg::DEPTH_BITS;

    // stack memory, one array per field
    logic [INDEX_BITS-1:0] mem_index [STACK_DEPTH];
    logic [LINE_BITS-1:0]  mem_start [STACK_DEPTH];
    logic [DB-1:0]         mem_depth [STACK_DEPTH];

    logic [CNT_W-1:0]      count_reg;
    logic [INDEX_BITS-1:0] next_index_reg;
    logic                  overflow_reg;

    logic                  is_end_reg;
    logic [LINE_BITS-1:0]  start_reg;
    logic [LINE_BITS-1:0]  close_reg;
    logic [DB-1:0]         dep_reg;

    logic [INDEX_BITS-1:0] rd_index_reg;
    logic [LINE_BITS-1:0]  rd_start_reg;
    logic [DB-1:0]         rd_depth_reg;

    logic                  pend_valid_reg;
    logic [INDEX_BITS-1:0] pend_index_reg;
    logic [LINE_BITS-1:0]  pend_start_reg;
    logic [DB-1:0]         pend_depth_reg;

    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg;
    logic                  m_user_reg;
    logic                  m_last_reg;

    logic [LINE_BITS-1:0]  in_line;
    logic [DB-1:0]         in_depth;
    logic [LINE_BITS-1:0]  in_count;
    logic [LINE_BITS-1:0]  in_start;
    logic [LINE_BITS-1:0]  entry_close;
    logic [LINE_BITS-1:0]  doc_close;
    logic [CNT_W-1:0]      top_addr;
    logic                  has_room;

    assign in_line  = s_tdata[LINE_BITS-1:0];
    assign in_depth = s_tdata[LINE_BITS+DB-1:LINE_BITS];
    assign in_count = s_tdata[2*LINE_BITS+DB-1:LINE_BITS+DB];

    // saturating decrements, no wrap below line 0
    assign in_start    = (in_line != '0) ? in_line - LINE_BITS'(1) : '0;
    assign entry_close = (in_start != '0) ? in_start - LINE_BITS'(1) : '0;
    assign doc_close   = (in_count != '0) ? in_count - LINE_BITS'(1) : '0;

    assign top_addr = count_reg - CNT_W'(1);
    assign has_room = (count_reg < CNT_W'(STACK_DEPTH));

    assign status.closes     = (s_tuser == nrc_pkg::OP_ENTRY) || (s_tuser == nrc_pkg::OP_END);
    assign status.pop_ok     = (count_reg != '0) && (is_end_reg || (rd_depth_reg >= dep_reg));
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = !m_valid_reg || m_tready;

    // stack memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.finish && !is_end_reg && has_room) begin
            mem_index[count_reg[PTR_W-1:0]] <= next_index_reg;
            mem_start[count_reg[PTR_W-1:0]] <= start_reg;
            mem_depth[count_reg[PTR_W-1:0]] <= dep_reg;
        end
        if (cmd.read) begin
            rd_index_reg <= mem_index[top_addr[PTR_W-1:0]];
            rd_start_reg <= mem_start[top_addr[PTR_W-1:0]];
            rd_depth_reg <= mem_depth[top_addr[PTR_W-1:0]];
        end
    end

    // item and pending payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            is_end_reg <= (s_tuser == nrc_pkg::OP_END);
            start_reg  <= in_start;
            close_reg  <= (s_tuser == nrc_pkg::OP_END) ? doc_close : entry_close;
            dep_reg    <= in_depth;
        end
        if (cmd.pop) begin
            pend_index_reg <= rd_index_reg;
            pend_start_reg <= rd_start_reg;
            pend_depth_reg <= rd_depth_reg;
        end
        if (cmd.emit) begin
            m_data_reg <= M_TDATA_W'({pend_depth_reg, close_reg, pend_start_reg,
                                      pend_index_reg});
            m_user_reg <= overflow_reg;
            m_last_reg <= cmd.emit_last;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            next_index_reg <= '0;
            overflow_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.accept && (s_tuser == nrc_pkg::OP_SLOT)) begin
                next_index_reg <= next_index_reg + INDEX_BITS'(1);
            end
            if (cmd.pop) begin
                count_reg      <= top_addr;
                pend_valid_reg <= 1'b1;
            end else if (cmd.clear_pend) begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.finish) begin
                if (is_end_reg) begin
                    next_index_reg <= '0;
                end else begin
                    next_index_reg <= next_index_reg + INDEX_BITS'(1);
                    if (has_room) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end else begin
                        overflow_reg <= 1'b1;
                    end
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

[hdl/nrc_ctrl.sv]
// controller: sequences accept, stack fetch, close decision and final push
// depends on nrc_pkg
module nrc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  nrc_pkg::status_t  status,
    output nrc_pkg::cmd_t     cmd
);

    nrc_pkg::state_t state_reg;
    nrc_pkg::state_t state_next;
    logic            accept;

    assign s_tready = (state_reg == nrc_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nrc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nrc_pkg::ST_IDLE: begin
                if (accept && status.closes) begin
                    state_next = nrc_pkg::ST_READ;
                end
            end
            nrc_pkg::ST_READ: begin
                state_next = nrc_pkg::ST_DECIDE;
            end
            nrc_pkg::ST_DECIDE: begin
                if (status.pop_ok) begin
                    if (!status.pend_valid || status.out_free) begin
                        state_next = nrc_pkg::ST_READ;
                    end
                end else if (status.pend_valid) begin
                    state_next = nrc_pkg::ST_FLUSH;
                end else begin
                    state_next = nrc_pkg::ST_IDLE;
                end
            end
            nrc_pkg::ST_FLUSH: begin
                if (status.out_free) begin
                    state_next = nrc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.accept = accept;
        case (state_reg)
            nrc_pkg::ST_IDLE: begin
            end
            nrc_pkg::ST_READ: begin
                cmd.read = 1'b1;
            end
            nrc_pkg::ST_DECIDE: begin
                if (status.pop_ok) begin
                    // older pending range is known not to be last once another pops
                    if (!status.pend_valid || status.out_free) begin
                        cmd.pop  = 1'b1;
                        cmd.emit = status.pend_valid;
                    end
                end else if (!status.pend_valid) begin
                    cmd.finish = 1'b1;
                end
            end
            nrc_pkg::ST_FLUSH: begin
                if (status.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_last  = 1'b1;
                    cmd.clear_pend = 1'b1;
                    cmd.finish     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[hdl/nesting_range_closer.sv]
// Nesting range closer. Takes outline entries (line, depth), empty slots and
// end-of-document words on s_; each entry closes the open entries on the stack
// whose depth is at least its own, and every closed range leaves on m_ as one
// word, in closing order, with m_tlast on the last word of the input word that
// caused it. m_tuser carries the sticky overflow flag: a new entry that finds
// the stack full after its pops is dropped. Slot words and undefined ops
// leave the block in ST_IDLE; an entry or end-of-document word passes through
// ST_READ and ST_DECIDE once per closed range and once more for the final check,
// then through ST_FLUSH to hand over the last word when it closed a range.
// The stack's single registered read port makes each close fetch the top entry,
// then compare its depth. Output stalls hold the block only when a closed word
// meets a full output register. Depends on nrc_pkg, nrc_ctrl and nrc_datapath.
module nesting_range_closer #(
    parameter int   STACK_DEPTH = 32,
    parameter int   LINE_BITS   = 24,
    parameter int   INDEX_BITS  = 16,
    localparam int  S_FIELD_W   = 2 * LINE_BITS + nrc_pkg::DEPTH_BITS,
    localparam int  S_TDATA_W   = ((S_FIELD_W + 7) / 8) * 8,
    localparam int  M_FIELD_W   = INDEX_BITS + 2 * LINE_BITS + nrc_pkg::DEPTH_BITS,
    localparam int  M_TDATA_W   = ((M_FIELD_W + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // line_number, depth, doc_line_count
    input  logic [S_TDATA_W-1:0]         s_tdata,
    // op
    input  logic [nrc_pkg::OP_BITS-1:0]  s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // entry_index, start_line, end_line, range_depth
    output logic [M_TDATA_W-1:0]         m_tdata,
    // overflow
    output logic                         m_tuser,
    output logic                         m_tlast
);

    nrc_pkg::cmd_t    cmd;
    nrc_pkg::status_t status;

    nrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nrc_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BITS   (LINE_BITS),
        .INDEX_BITS  (INDEX_BITS),
        .S_TDATA_W   (S_TDATA_W),
        .M_TDATA_W   (M_TDATA_W)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

[hdl/nrc_checker.sv]
// port-level checker for the nesting range closer, bound to the top level
// depends on nrc_pkg and nesting_range_closer_assert.svh
`include "nesting_range_closer_assert.svh"

module nrc_checker #(
    parameter int S_TDATA_W = 56,
    parameter int M_TDATA_W = 72
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [S_TDATA_W-1:0]         s_tdata,
    input logic [nrc_pkg::OP_BITS-1:0]  s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [M_TDATA_W-1:0]         m_tdata,
    input logic                         m_tuser,
    input logic                         m_tlast
);

    logic ovf_seen_reg;

    // remembers whether any word has shown the overflow flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_seen_reg <= 1'b0;
        end else if (m_tvalid && m_tuser) begin
            ovf_seen_reg <= 1'b1;
        end
    end

    `NRC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `NRC_ASSERT_SAME(a_ovf_sticky, aclk, aresetn, m_tvalid && ovf_seen_reg, m_tuser)
    `NRC_ASSERT_NEXT(a_busy_after_close, aclk, aresetn, s_tvalid && s_tready && (s_tuser == nrc_pkg::OP_ENTRY || s_tuser == nrc_pkg::OP_END), !s_tready)

endmodule

bind nesting_range_closer nrc_checker #(
    .S_TDATA_W (S_TDATA_W),
    .M_TDATA_W (M_TDATA_W)
) u_nrc_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 1ps
// testbench for nesting_range_closer: outline entries, empty slots and end-of-document words
// go in, closed fold ranges are predicted in order and checked word by word as they leave
// depends on nrc_pkg and nesting_range_closer
module testbench;

    localparam int STACK_DEPTH = 32;
    localparam int LINE_BITS   = 24;
    localparam int INDEX_BITS  = 16;
    localparam int S_W         = ((2 * LINE_BITS + nrc_pkg::DEPTH_BITS + 7) / 8) * 8;
    localparam int M_W         = ((INDEX_BITS + 2 * LINE_BITS + nrc_pkg::DEPTH_BITS + 7) / 8) * 8;
    localparam int CLK_PERIOD  = 10;
    localparam int WATCHDOG    = 5000;
    localparam int TAIL_CYCLES = 100;
    localparam int SHOWN_ERRS  = 10;
    localparam logic [nrc_pkg::OP_BITS-1:0] OP_UNDEF = 2'd3;
    localparam bit [LINE_BITS-1:0] LINE_MAX = '1;

    typedef struct packed {
        bit [INDEX_BITS-1:0] idx;
        bit [LINE_BITS-1:0]  first;
        bit [LINE_BITS-1:0]  stop;
        bit [7:0]            dep;
        bit                  ovf;
        bit                  is_last;
    } fold_t;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    // line_number, depth, doc_line_count
    logic [S_W-1:0]               s_tdata  = '0;
    // op
    logic [nrc_pkg::OP_BITS-1:0]  s_tuser  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    // entry_index, start_line, end_line, range_depth
    logic [M_W-1:0]               m_tdata;
    // overflow
    logic                         m_tuser;
    logic                         m_tlast;

    // open entry stack as the block should hold it
    bit [INDEX_BITS-1:0] open_idx[STACK_DEPTH];
    bit [LINE_BITS-1:0]  open_first[STACK_DEPTH];
    bit [7:0]            open_dep[STACK_DEPTH];
    int                  open_cnt = 0;
    bit [INDEX_BITS-1:0] next_idx = '0;
    bit                  ovf_seen = 1'b0;

    fold_t pending_folds[$];
    int    mismatches    = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    recv_hold     = 0;
    int    quiet_cycles  = 0;

    nesting_range_closer #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BITS   (LINE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // receiver: long hold-off when requested, random stalls otherwise
    always @(negedge aclk) begin
        if (recv_hold > 0) begin
            m_tready <= 1'b0;
            recv_hold = recv_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge aclk) begin : fold_check
        fold_t got;
        fold_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.idx     = m_tdata[INDEX_BITS-1:0];
            got.first   = m_tdata[INDEX_BITS +: LINE_BITS];
            got.stop    = m_tdata[INDEX_BITS + LINE_BITS +: LINE_BITS];
            got.dep     = m_tdata[INDEX_BITS + 2 * LINE_BITS +: 8];
            got.ovf     = m_tuser;
            got.is_last = m_tlast;
            if (pending_folds.size() == 0) begin
                if (mismatches < SHOWN_ERRS)
                    $display("unexpected word: idx=%0d first=%0d stop=%0d dep=%0d ovf=%0b last=%0b",
                             got.idx, got.first, got.stop, got.dep, got.ovf, got.is_last);
                mismatches++;
            end else begin
                want = pending_folds.pop_front();
                if (got != want) begin
                    if (mismatches < SHOWN_ERRS) begin
                        $display("wrong word: expected idx=%0d first=%0d stop=%0d dep=%0d ovf=%0b last=%0b",
                                 want.idx, want.first, want.stop, want.dep, want.ovf, want.is_last);
                        $display("            actual   idx=%0d first=%0d stop=%0d dep=%0d ovf=%0b last=%0b",
                                 got.idx, got.first, got.stop, got.dep, got.ovf, got.is_last);
                    end
                    mismatches++;
                end
            end
        end
    end

    function automatic fold_t pop_open(input bit [LINE_BITS-1:0] stop);
        fold_t f;
        open_cnt  = open_cnt - 1;
        f.idx     = open_idx[open_cnt];
        f.first   = open_first[open_cnt];
        f.stop    = stop;
        f.dep     = open_dep[open_cnt];
        f.ovf     = 1'b0;
        f.is_last = 1'b0;
        return f;
    endfunction

    // works out the ranges one accepted word closes and queues them
    task automatic close_ranges(input logic [nrc_pkg::OP_BITS-1:0] op,
                                input bit [LINE_BITS-1:0] line_no,
                                input bit [7:0] dep, input bit [LINE_BITS-1:0] doc_lines);
        fold_t                closed[$];
        bit [LINE_BITS-1:0]   first_line;
        bit [LINE_BITS-1:0]   cut_line;
        case (op)
            nrc_pkg::OP_ENTRY: begin
                first_line = (line_no > 0) ? line_no - 1'b1 : '0;
                cut_line   = (first_line > 0) ? first_line - 1'b1 : '0;
                while (open_cnt > 0 && open_dep[open_cnt-1] >= dep)
                    closed = {closed, pop_open(cut_line)};
                if (open_cnt < STACK_DEPTH) begin
                    open_idx[open_cnt]   = next_idx;
                    open_first[open_cnt] = first_line;
                    open_dep[open_cnt]   = dep;
                    open_cnt++;
                end else begin
                    ovf_seen = 1'b1;
                end
                next_idx++;
            end
            nrc_pkg::OP_SLOT: begin
                next_idx++;
            end
            nrc_pkg::OP_END: begin
                cut_line = (doc_lines > 0) ? doc_lines - 1'b1 : '0;
                while (open_cnt > 0)
                    closed = {closed, pop_open(cut_line)};
                next_idx = '0;
            end
            default: ;
        endcase
        foreach (closed[k]) begin
            closed[k].ovf     = ovf_seen;
            closed[k].is_last = (k == closed.size() - 1);
            pending_folds = {pending_folds, closed[k]};
        end
    endtask

    // valid stays high between words but for random gaps; pausing callers use wait_drain
    task automatic send_word(input logic [nrc_pkg::OP_BITS-1:0] op,
                             input bit [LINE_BITS-1:0] line_no,
                             input bit [7:0] dep, input bit [LINE_BITS-1:0] doc_lines);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_W'({doc_lines, dep, line_no});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        close_ranges(op, line_no, dep, doc_lines);
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_folds.size() != 0) @(negedge aclk);
    endtask

    task automatic test_nesting_order();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_word(nrc_pkg::OP_ENTRY, 1, 0, 0);
        send_word(nrc_pkg::OP_ENTRY, 5, 1, 0);
        send_word(nrc_pkg::OP_ENTRY, 9, 2, 0);
        // closes depth 2 then depth 1, keeps depth 0
        send_word(nrc_pkg::OP_ENTRY, 12, 1, 0);
        send_word(nrc_pkg::OP_SLOT, 0, 0, 0);
        send_word(nrc_pkg::OP_ENTRY, 15, 3, 0);
        send_word(nrc_pkg::OP_ENTRY, 20, 0, 0);
        send_word(nrc_pkg::OP_END, 0, 0, 30);
        wait_drain();
    endtask

    task automatic test_line_extremes();
        send_word(nrc_pkg::OP_ENTRY, LINE_MAX, 8'hFF, 0);
        // line zero saturates, closed range ends on line 0
        send_word(nrc_pkg::OP_ENTRY, 0, 8'hFF, LINE_MAX);
        send_word(OP_UNDEF, LINE_MAX, 8'hFF, LINE_MAX);
        send_word(nrc_pkg::OP_ENTRY, 1, 0, 0);
        send_word(nrc_pkg::OP_ENTRY, 2, 0, 0);
        // empty document closes at line 0
        send_word(nrc_pkg::OP_END, LINE_MAX, 8'hFF, 0);
        send_word(nrc_pkg::OP_END, 0, 0, LINE_MAX);
        send_word(nrc_pkg::OP_ENTRY, 3, 8'h80, 0);
        send_word(OP_UNDEF, 0, 0, 0);
        send_word(nrc_pkg::OP_SLOT, LINE_MAX, 8'hFF, LINE_MAX);
        send_word(nrc_pkg::OP_END, 0, 0, LINE_MAX);
        wait_drain();
    endtask

    // mostly well-formed documents with rising lines, plus slots, junk ops and odd lines
    task automatic test_random_documents(input int n_words, input int s_pct, input int r_pct);
        int                 sent;
        int                 n_entries;
        int                 roll;
        bit [LINE_BITS-1:0] line_at;
        bit [LINE_BITS-1:0] line_no;
        bit [7:0]           dep;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_words) begin
            n_entries = $urandom_range(1, 12);
            line_at = ($urandom_range(3) == 0) ? LINE_BITS'($urandom_range(0, LINE_MAX))
                                               : LINE_BITS'($urandom_range(1, 500));
            for (int k = 0; k < n_entries; k++) begin
                roll = $urandom_range(99);
                if (roll < 8) begin
                    send_word(nrc_pkg::OP_SLOT, LINE_BITS'($urandom_range(0, LINE_MAX)),
                              8'($urandom_range(0, 255)),
                              LINE_BITS'($urandom_range(0, LINE_MAX)));
                    sent++;
                end else if (roll < 12) begin
                    send_word(OP_UNDEF, LINE_BITS'($urandom_range(0, LINE_MAX)),
                              8'($urandom_range(0, 255)),
                              LINE_BITS'($urandom_range(0, LINE_MAX)));
                end else begin
                    line_at = line_at + LINE_BITS'($urandom_range(1, 40));
                    line_no = ($urandom_range(9) == 0) ? LINE_BITS'($urandom_range(0, LINE_MAX))
                                                       : line_at;
                    dep = ($urandom_range(4) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 6));
                    send_word(nrc_pkg::OP_ENTRY, line_no, dep,
                              LINE_BITS'($urandom_range(0, LINE_MAX)));
                    sent++;
                end
            end
            roll = $urandom_range(9);
            if (roll != 0) begin
                send_word(nrc_pkg::OP_END, LINE_BITS'($urandom_range(0, LINE_MAX)),
                          8'($urandom_range(0, 255)),
                          (roll == 1) ? LINE_BITS'($urandom_range(0, LINE_MAX))
                                      : line_at + LINE_BITS'($urandom_range(0, 20)));
                sent++;
            end
        end
        wait_drain();
    endtask

    task automatic test_stack_full();
        send_word(nrc_pkg::OP_END, 0, 0, 1);
        for (int k = 1; k <= STACK_DEPTH; k++)
            send_word(nrc_pkg::OP_ENTRY, LINE_BITS'(10 * k), 8'(k), 0);
        // no pops, so the entry is dropped and overflow sticks
        send_word(nrc_pkg::OP_ENTRY, 400, 8'(STACK_DEPTH + 1), 0);
        send_word(nrc_pkg::OP_ENTRY, 410, 8'(STACK_DEPTH), 0);
        send_word(nrc_pkg::OP_ENTRY, 420, 200, 0);
        // one word closes the whole stack
        send_word(nrc_pkg::OP_ENTRY, 500, 0, 0);
        send_word(nrc_pkg::OP_END, 0, 0, 600);
        wait_drain();
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 300;
        // same depth, so every entry closes the one before and the output backs up
        for (int k = 0; k < 10; k++)
            send_word(nrc_pkg::OP_ENTRY, LINE_BITS'(10 * k + 1), 3, 0);
        send_word(nrc_pkg::OP_END, 0, 0, 250);
        // sender stays quiet until the last range has come out
        wait_drain();
        send_word(nrc_pkg::OP_ENTRY, 7, 9, 0);
        send_word(nrc_pkg::OP_END, 0, 0, 9);
        wait_drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_nesting_order();
        test_line_extremes();
        test_random_documents(8, 31, 87);
        test_random_documents(8, 87, 31);
        test_stack_full();
        test_output_stall();
        test_random_documents(8, 0, 0);
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_folds.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/nrc_pkg.sv
hdl/nrc_datapath.sv
hdl/nrc_ctrl.sv
hdl/nesting_range_closer.sv
hdl/nrc_checker.sv
dv/testbench.sv
